// ----- rtl/core/hps_pkg.sv -----
// Shared types and constants of the heap process scheduler.
// Depends on nothing; imported by hps_key_mul and heap_process_scheduler_top.
package hps_pkg;

	localparam int KEY_W = 49;

	localparam logic CMD_ADD = 1'b0;
	localparam logic CMD_RUN = 1'b1;

	localparam logic [2:0] ST_ADDED     = 3'd0;
	localparam logic [2:0] ST_FULL      = 3'd1;
	localparam logic [2:0] ST_EMPTY     = 3'd2;
	localparam logic [2:0] ST_REQUEUED  = 3'd3;
	localparam logic [2:0] ST_COMPLETED = 3'd4;

	typedef struct packed {
		logic        cmd;
		logic [15:0] new_priority;
		logic [30:0] new_full_time;
	} in_word_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] served_priority;
		logic [31:0] served_elapsed;
		logic [30:0] served_full_time;
		logic [31:0] steps_done;
		logic [6:0]  queue_count;
	} out_word_t;

	typedef struct packed {
		logic [15:0] prio;
		logic [31:0] elapsed;
		logic [30:0] full_time;
	} entry_t;

endpackage

// ----- rtl/core/hps_key_mul.sv -----
// Heap key of one process: priority * (elapsed + 1), exact 49-bit product.
// Depends on hps_pkg.
module hps_key_mul (
	input  hps_pkg::entry_t                ent,
	output logic [hps_pkg::KEY_W-1:0]      key
);
	import hps_pkg::*;

	logic [32:0] elapsed_inc;

	assign elapsed_inc = {1'b0, ent.elapsed} + 33'd1;
	assign key = KEY_W'(ent.prio) * KEY_W'(elapsed_inc);

endmodule

// ----- rtl/core/heap_process_scheduler_top.sv -----
// Heap process scheduler: sequencer around one heap memory.
// Depends on hps_pkg and hps_key_mul.
//
// Usage:
//   Present a word on item and raise start; it is taken at a rising edge where
//   busy is low. cmd = add inserts a process (elapsed zero) and sifts it up;
//   cmd = run serves the least-key process (key = priority * (elapsed + 1)),
//   adds its priority to its elapsed time and re-inserts it unless it is done.
//   Exactly one result word follows each item, shown on result for one cycle
//   with done high. The receiver cannot hold it off; capture it on that cycle.
//   busy stays high from the accepting edge until the result is shown, and a
//   new item may be taken in the same cycle that done is high.
// Steps per item (a rejected add or a run on an empty heap stays in IDLE):
//   Add: UP_KEY keys the new process; UP_MUL and UP_CMP compare one parent
//   per level on the way up; WR_CUR writes it. Run: S_ROOT and S_LAST read
//   root and tail, DN_KEY keys the tail; per level DN_CHK, DN_LMUL, DN_RMUL
//   (if a right child exists), DN_SEL and DN_CMP sift it down, DN_PUT writes
//   it, and a requeue climbs as an add does. All heap traffic goes through
//   the single read and write port of the heap memory, and every key comes
//   from one shared multiplier.
// Reset:
//   arst_n clears the entry count, the execution counter and the sequencer.
//   The heap memory is not cleared; only slots below the count are ever used.
module heap_process_scheduler_top #(
	parameter int HEAP_DEPTH = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  hps_pkg::in_word_t   item,
	output logic                busy,
	output logic                done,
	output hps_pkg::out_word_t  result
);
	import hps_pkg::*;

	localparam int AW  = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
	localparam int CW  = $clog2(HEAP_DEPTH + 1);
	localparam int CHW = CW + 1;

	typedef enum logic [13:0] {
		IDLE    = 14'b00000000000001,
		UP_KEY  = 14'b00000000000010,
		UP_MUL  = 14'b00000000000100,
		UP_CMP  = 14'b00000000001000,
		WR_CUR  = 14'b00000000010000,
		S_ROOT  = 14'b00000000100000,
		S_LAST  = 14'b00000001000000,
		DN_KEY  = 14'b00000010000000,
		DN_CHK  = 14'b00000100000000,
		DN_LMUL = 14'b00001000000000,
		DN_RMUL = 14'b00010000000000,
		DN_SEL  = 14'b00100000000000,
		DN_CMP  = 14'b01000000000000,
		DN_PUT  = 14'b10000000000000
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     count_q;
	logic [31:0]       steps_q;
	logic [AW-1:0]     pos_q;
	logic [AW-1:0]     par_q;
	logic [AW-1:0]     pick_q;
	logic              has_r_q;
	entry_t            cur_q;
	entry_t            served_q;
	entry_t            ent_l_q;
	entry_t            ent_r_q;
	entry_t            ent_p_q;
	logic [KEY_W-1:0]  key_cur_q;
	logic [KEY_W-1:0]  key_l_q;
	logic [KEY_W-1:0]  key_r_q;
	logic [KEY_W-1:0]  key_p_q;
	logic              done_q;
	out_word_t         res_q;

	// heap memory, one port each way, registered read
	entry_t            heap_mem [HEAP_DEPTH];
	entry_t            rd_q;
	logic [AW-1:0]     rd_addr;
	logic              we;
	logic [AW-1:0]     wr_addr;
	entry_t            wr_data;

	entry_t            mul_in;
	logic [KEY_W-1:0]  mul_key;

	logic [CHW-1:0]    left_w;
	logic [CHW-1:0]    right_w;
	logic [AW-1:0]     pos_par;
	logic [AW-1:0]     par_par;
	logic [31:0]       new_elapsed;

	assign left_w  = CHW'({pos_q, 1'b0}) + CHW'(1);
	assign right_w = left_w + CHW'(1);
	assign pos_par = AW'((pos_q - AW'(1)) >> 1);
	assign par_par = AW'((par_q - AW'(1)) >> 1);
	assign new_elapsed = served_q.elapsed + 32'(served_q.prio);

	hps_key_mul u_key_mul (
		.ent (mul_in),
		.key (mul_key)
	);

	// key source: the moving process while its key is formed, else read data
	always_comb begin
		mul_in = rd_q;
		if (state_q == UP_KEY || state_q == DN_KEY) begin
			mul_in = cur_q;
		end
	end

	// memory address and write selection
	always_comb begin
		rd_addr = '0;
		we      = 1'b0;
		wr_addr = pos_q;
		wr_data = cur_q;
		case (state_q)
			IDLE:    rd_addr = '0;
			UP_KEY:  rd_addr = pos_par;
			UP_CMP: begin
				rd_addr = par_par;
				if (key_p_q > key_cur_q) begin
					we      = 1'b1;
					wr_data = ent_p_q;
				end
			end
			WR_CUR:  we = 1'b1;
			S_ROOT:  rd_addr = AW'(count_q - CW'(1));
			DN_CHK:  rd_addr = AW'(left_w);
			DN_LMUL: rd_addr = AW'(right_w);
			DN_CMP: begin
				if (key_cur_q > key_p_q) begin
					we      = 1'b1;
					wr_data = ent_p_q;
				end
			end
			DN_PUT:  we = 1'b1;
			default: rd_addr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			heap_mem[wr_addr] <= wr_data;
		end
		rd_q <= heap_mem[rd_addr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			count_q <= '0;
			steps_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				IDLE: begin
					if (start) begin
						if (item.cmd == CMD_ADD) begin
							res_q.served_priority  <= '0;
							res_q.served_elapsed   <= '0;
							res_q.served_full_time <= '0;
							if (count_q >= CW'(HEAP_DEPTH)) begin
								// full: drop the word
								res_q.status      <= ST_FULL;
								res_q.steps_done  <= steps_q;
								res_q.queue_count <= 7'(count_q);
								done_q            <= 1'b1;
							end else begin
								res_q.status   <= ST_ADDED;
								cur_q.prio      <= item.new_priority;
								cur_q.elapsed   <= '0;
								cur_q.full_time <= item.new_full_time;
								pos_q           <= AW'(count_q);
								count_q         <= count_q + CW'(1);
								state_q         <= UP_KEY;
							end
						end else if (count_q == '0) begin
							res_q.status           <= ST_EMPTY;
							res_q.served_priority  <= '0;
							res_q.served_elapsed   <= '0;
							res_q.served_full_time <= '0;
							res_q.steps_done       <= steps_q;
							res_q.queue_count      <= 7'(count_q);
							done_q                 <= 1'b1;
						end else begin
							state_q <= S_ROOT;
						end
					end
				end
				UP_KEY: begin
					key_cur_q <= mul_key;
					par_q     <= pos_par;
					state_q   <= (pos_q == '0) ? WR_CUR : UP_MUL;
				end
				UP_MUL: begin
					key_p_q <= mul_key;
					ent_p_q <= rd_q;
					state_q <= UP_CMP;
				end
				UP_CMP: begin
					// parent strictly greater: move it down, climb one level
					if (key_p_q > key_cur_q) begin
						pos_q <= par_q;
						par_q <= par_par;
						state_q <= (par_q == '0) ? WR_CUR : UP_MUL;
					end else begin
						state_q <= WR_CUR;
					end
				end
				WR_CUR: begin
					res_q.steps_done  <= steps_q;
					res_q.queue_count <= 7'(count_q);
					done_q            <= 1'b1;
					state_q           <= IDLE;
				end
				S_ROOT: begin
					served_q <= rd_q;
					state_q  <= S_LAST;
				end
				S_LAST: begin
					cur_q   <= rd_q;
					count_q <= count_q - CW'(1);
					pos_q   <= '0;
					if (steps_q != '1) begin
						steps_q <= steps_q + 32'd1;
					end
					state_q <= DN_KEY;
				end
				DN_KEY: begin
					key_cur_q <= mul_key;
					state_q   <= DN_CHK;
				end
				DN_CHK: begin
					state_q <= (left_w >= CHW'(count_q)) ? DN_PUT : DN_LMUL;
				end
				DN_LMUL: begin
					key_l_q <= mul_key;
					ent_l_q <= rd_q;
					has_r_q <= (right_w < CHW'(count_q));
					state_q <= (right_w < CHW'(count_q)) ? DN_RMUL : DN_SEL;
				end
				DN_RMUL: begin
					key_r_q <= mul_key;
					ent_r_q <= rd_q;
					state_q <= DN_SEL;
				end
				DN_SEL: begin
					// smaller child, left on a tie
					if (has_r_q && (key_r_q < key_l_q)) begin
						key_p_q <= key_r_q;
						ent_p_q <= ent_r_q;
						pick_q  <= AW'(right_w);
					end else begin
						key_p_q <= key_l_q;
						ent_p_q <= ent_l_q;
						pick_q  <= AW'(left_w);
					end
					state_q <= DN_CMP;
				end
				DN_CMP: begin
					if (key_cur_q > key_p_q) begin
						pos_q   <= pick_q;
						state_q <= DN_CHK;
					end else begin
						state_q <= DN_PUT;
					end
				end
				DN_PUT: begin
					res_q.served_priority  <= served_q.prio;
					res_q.served_elapsed   <= new_elapsed;
					res_q.served_full_time <= served_q.full_time;
					if (new_elapsed >= {1'b0, served_q.full_time}) begin
						res_q.status      <= ST_COMPLETED;
						res_q.steps_done  <= steps_q;
						res_q.queue_count <= 7'(count_q);
						done_q            <= 1'b1;
						state_q           <= IDLE;
					end else begin
						// requeue at the tail and climb
						res_q.status    <= ST_REQUEUED;
						cur_q.prio      <= served_q.prio;
						cur_q.elapsed   <= new_elapsed;
						cur_q.full_time <= served_q.full_time;
						pos_q           <= AW'(count_q);
						count_q         <= count_q + CW'(1);
						state_q         <= UP_KEY;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign busy   = (state_q != IDLE);
	assign done   = done_q;
	assign result = res_q;

	// finishing a multi-cycle item always shows a result word
	a_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy fell without a result word");

	// a full heap rejects an add at once
	a_full_rej: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.cmd == CMD_ADD && count_q >= CW'(HEAP_DEPTH))
		|=> (done && result.status == ST_FULL))
		else $error("add on full heap not rejected");

	// the count never passes the heap depth
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(HEAP_DEPTH))
		else $error("entry count beyond heap depth");

	// a run on an empty heap leaves the execution counter alone
	a_empty_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.cmd == CMD_RUN && count_q == '0) |=> $stable(steps_q))
		else $error("execution counter moved on empty run");

endmodule
